@@ hw/rtl/vwt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vwt_pkg;

    localparam int COORD_BITS = 24;
    localparam int THRESH_W   = 52;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int SUM_W      = SQ_W + 2;
    localparam int VERT_W     = 3 * COORD_BITS;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 52'd167772;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNIQUE_FULL = 2'd1;
    localparam logic [1:0] ST_INPUT_FULL  = 2'd2;
    localparam logic [1:0] ST_UNMAPPED    = 2'd3;

    localparam logic ADDR_THRESH = 1'b0;

    typedef struct packed {
        logic [1:0]             operation;
        logic signed [23:0]     x_coord;
        logic signed [23:0]     y_coord;
        logic signed [23:0]     z_coord;
        logic [9:0]             original_index;
    } item_t;

    typedef struct packed {
        logic [7:0] unique_index;
        logic       is_new;
        logic [1:0] status;
        logic [8:0] unique_count;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/vwt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/vertex_weld_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Vertex weld table. An add transaction compares its Q12.12 vertex against the stored
// unique vertices in index order and returns the first one closer than weld_threshold
// (squared distance, 24 fraction bits), else appends it while there is room; the
// original-to-unique mapping is recorded for every add that succeeds and a lookup
// transaction reads it back. The unique vertex RAM is read once per cycle and each read
// flows through diff, square and sum/compare stages; the scan stops at the first hit.
// An add refused because the input table is full, a clear and a no-op go straight to
// the finish state; a mapped lookup reads the remap RAM first. One transaction is
// worked on at a time; the next is taken while the previous result waits in the output
// register. Clear only resets the fill counts, so no RAM sweep is needed.
module vertex_weld_table #(
    parameter int MAX_UNIQUE = 256,
    parameter int MAX_INPUT  = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire vwt_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output vwt_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [63:0]      pwdata,
    output logic      [63:0]      prdata,
    output logic                  pready
);

    import vwt_pkg::*;

    localparam int UAW = $clog2(MAX_UNIQUE);
    localparam int UCW = $clog2(MAX_UNIQUE + 1);
    localparam int LAW = $clog2(MAX_INPUT);
    localparam int LCW = $clog2(MAX_INPUT + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [1:0]                 op_reg, op_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [UCW-1:0]             issue_reg, issue_next;
    logic                       va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    logic [UAW-1:0]             ja_reg, ja_next, jb_reg, jb_next, jc_reg, jc_next;
    logic signed [DIFF_W-1:0]   dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [SQ_W-1:0]            sqx_reg, sqx_next, sqy_reg, sqy_next, sqz_reg, sqz_next;
    logic [UAW-1:0]             res_idx_reg, res_idx_next;
    logic                       res_new_reg, res_new_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic [UCW-1:0]             unique_total_reg, unique_total_next;
    logic [LCW-1:0]             loaded_total_reg, loaded_total_next;
    logic [THRESH_W-1:0]        thresh_reg, thresh_next;
    logic                       result_valid_reg, result_valid_next;
    result_t                    result_reg, result_next;

    logic                       uq_we;
    logic [UAW-1:0]             uq_waddr, uq_raddr;
    logic [VERT_W-1:0]          uq_wdata, uq_rdata;
    logic                       rm_we;
    logic [LAW-1:0]             rm_waddr, rm_raddr;
    logic [UAW-1:0]             rm_wdata, rm_rdata;

    logic                       accept, commit, cfg_write;
    logic                       hit, scan_done, issue_now;
    logic [SUM_W-1:0]           sq_sum;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;
    logic [31:0]                oidx_wide, loaded_wide, idx_wide, cnt_wide;
    logic [UCW-1:0]             count_after;

    vwt_ram #(
        .WIDTH(VERT_W),
        .DEPTH(MAX_UNIQUE)
    ) u_unique_ram (
        .clk  (clk),
        .we   (uq_we),
        .waddr(uq_waddr),
        .wdata(uq_wdata),
        .raddr(uq_raddr),
        .rdata(uq_rdata)
    );

    vwt_ram #(
        .WIDTH(UAW),
        .DEPTH(MAX_INPUT)
    ) u_remap_ram (
        .clk  (clk),
        .we   (rm_we),
        .waddr(rm_waddr),
        .wdata(rm_wdata),
        .raddr(rm_raddr),
        .rdata(rm_rdata)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;
    assign prdata       = (paddr[3] == ADDR_THRESH) ? 64'(thresh_reg) : 64'd0;

    assign oidx_wide   = 32'(item.original_index);
    assign loaded_wide = 32'(loaded_total_reg);

    // scan datapath: stage C sums the squares and compares
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;
    assign sq_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    assign hit    = vc_reg && (THRESH_W'(sq_sum) < thresh_reg);
    assign issue_now = (state_reg == S_SCAN) && !hit && (issue_reg < unique_total_reg);
    assign scan_done = !hit && !issue_now && !va_reg && !vb_reg;

    assign uq_raddr = issue_reg[UAW-1:0];
    assign rm_raddr = oidx_wide[LAW-1:0];

    assign commit = (state_reg == S_FINISH) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        issue_next        = issue_reg;
        res_idx_next      = res_idx_reg;
        res_new_next      = res_new_reg;
        res_status_next   = res_status_reg;
        unique_total_next = unique_total_reg;
        loaded_total_next = loaded_total_reg;
        thresh_next       = thresh_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        va_next           = issue_now;
        ja_next           = issue_reg[UAW-1:0];
        vb_next           = va_reg && (state_reg == S_SCAN) && !hit;
        jb_next           = ja_reg;
        vc_next           = vb_reg && (state_reg == S_SCAN) && !hit;
        jc_next           = jb_reg;
        dx_next = {x_reg[COORD_BITS-1], x_reg}
                - {uq_rdata[VERT_W-1], uq_rdata[VERT_W-1 -: COORD_BITS]};
        dy_next = {y_reg[COORD_BITS-1], y_reg}
                - {uq_rdata[2*COORD_BITS-1], uq_rdata[2*COORD_BITS-1 -: COORD_BITS]};
        dz_next = {z_reg[COORD_BITS-1], z_reg}
                - {uq_rdata[COORD_BITS-1], uq_rdata[COORD_BITS-1:0]};
        sqx_next = prod_x[SQ_W-1:0];
        sqy_next = prod_y[SQ_W-1:0];
        sqz_next = prod_z[SQ_W-1:0];
        uq_we    = 1'b0;
        uq_waddr = unique_total_reg[UAW-1:0];
        uq_wdata = {x_reg, y_reg, z_reg};
        rm_we    = 1'b0;
        rm_waddr = loaded_total_reg[LAW-1:0];
        rm_wdata = res_idx_reg;
        idx_wide    = 32'(res_idx_reg);
        count_after = unique_total_reg;

        if (cfg_write && paddr[3] == ADDR_THRESH)
        begin
            thresh_next = pwdata[THRESH_W-1:0];
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = item.operation;
                    x_next          = item.x_coord;
                    y_next          = item.y_coord;
                    z_next          = item.z_coord;
                    issue_next      = '0;
                    res_idx_next    = '0;
                    res_new_next    = 1'b0;
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                    unique case (item.operation)
                        OP_ADD:
                        begin
                            if (loaded_total_reg >= LCW'(MAX_INPUT))
                            begin
                                res_status_next = ST_INPUT_FULL;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (oidx_wide < loaded_wide && oidx_wide < 32'(MAX_INPUT))
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_status_next = ST_UNMAPPED;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue_now)
                begin
                    issue_next = issue_reg + UCW'(1);
                end
                if (hit)
                begin
                    res_idx_next = jc_reg;
                    state_next   = S_FINISH;
                end
                else if (scan_done)
                begin
                    if (unique_total_reg >= UCW'(MAX_UNIQUE))
                    begin
                        res_status_next = ST_UNIQUE_FULL;
                    end
                    else
                    begin
                        res_idx_next = unique_total_reg[UAW-1:0];
                        res_new_next = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                res_idx_next = rm_rdata;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (commit)
                begin
                    if (op_reg == OP_ADD && res_status_reg == ST_OK)
                    begin
                        rm_we             = 1'b1;
                        loaded_total_next = loaded_total_reg + LCW'(1);
                        if (res_new_reg)
                        begin
                            uq_we       = 1'b1;
                            count_after = unique_total_reg + UCW'(1);
                        end
                    end
                    else if (op_reg == OP_CLEAR)
                    begin
                        loaded_total_next = '0;
                        count_after       = '0;
                    end
                    unique_total_next         = count_after;
                    cnt_wide                  = 32'(count_after);
                    result_next.unique_index  = idx_wide[7:0];
                    result_next.is_new        = res_new_reg;
                    result_next.status        = res_status_reg;
                    result_next.unique_count  = cnt_wide[8:0];
                    result_valid_next         = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cnt_wide = 32'(count_after);
        result_next.unique_count = commit ? cnt_wide[8:0] : result_reg.unique_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            issue_reg        <= '0;
            va_reg           <= 1'b0;
            vb_reg           <= 1'b0;
            vc_reg           <= 1'b0;
            unique_total_reg <= '0;
            loaded_total_reg <= '0;
            thresh_reg       <= THRESH_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_reg        <= issue_next;
            va_reg           <= va_next;
            vb_reg           <= vb_next;
            vc_reg           <= vc_next;
            unique_total_reg <= unique_total_next;
            loaded_total_reg <= loaded_total_next;
            thresh_reg       <= thresh_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        ja_reg         <= ja_next;
        jb_reg         <= jb_next;
        jc_reg         <= jc_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        dz_reg         <= dz_next;
        sqx_reg        <= sqx_next;
        sqy_reg        <= sqy_next;
        sqz_reg        <= sqz_next;
        res_idx_reg    <= res_idx_next;
        res_new_reg    <= res_new_next;
        res_status_reg <= res_status_next;
        result_reg     <= result_next;
    end

    // a compared entry is always one already stored
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && vc_reg) |-> (UCW'(jc_reg) < unique_total_reg))
        else $error("scan compared an entry beyond the unique count");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= unique_total_reg))
        else $error("scan read address ran past the unique count");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_reg == OP_ADD && res_new_reg && res_status_reg == ST_OK)
        |=> (unique_total_reg == $past(unique_total_reg) + UCW'(1)))
        else $error("append did not advance the unique count");

    a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_new) |-> (result.status == ST_OK))
        else $error("new vertex reported with an error status");

    a_totals_bound: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (unique_total_reg <= UCW'(MAX_UNIQUE)
                    && loaded_total_reg <= LCW'(MAX_INPUT)))
        else $error("table count exceeded its capacity");

endmodule

`default_nettype wire
